// File: sv/mmrb_pkg.sv
// mmrb_pkg: shared types and constants for the min/max rescale-to-byte block.
// No dependencies; compiled first.
package mmrb_pkg;

   localparam int unsigned SampleWidthDefault = 16;
   localparam int unsigned LevelMax           = 255;
   localparam int unsigned LevelWidth         = 8;
   localparam int unsigned QuotBits           = 8;
   // bits needed for the 2*LevelMax scale factor
   localparam int unsigned ScaleBits          = $clog2(2 * LevelMax + 2);
   localparam int unsigned StepWidth          = $clog2(QuotBits);

   localparam logic OpMeasure = 1'b0;
   localparam logic OpRescale = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic measure;   // fold request sample into range
      logic capture;   // latch rescale sample
      logic prep;      // form offset, range and dividend
      logic div_step;  // one restoring-divide step
      logic load_out;  // move result into output register
   } cmd_type;

   typedef struct packed {
      logic is_rescale;  // request carries a rescale item
      logic out_free;    // output register can take a result this cycle
   } status_type;

endpackage

// File: sv/mmrb_channels.sv
// mmrb_channels: valid/ready channel interfaces for requests and responses.
// Depends on mmrb_pkg.
interface mmrb_req_if #(
   parameter int unsigned SAMPLE_WIDTH = mmrb_pkg::SampleWidthDefault
) ();
   import mmrb_pkg::*;

   logic                           valid;
   logic                           ready;
   logic                           opcode;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           last;

   modport source (output valid, opcode, sample, last, input ready);
   modport sink   (input valid, opcode, sample, last, output ready);
endinterface

interface mmrb_rsp_if ();
   import mmrb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [LevelWidth-1:0] level;
   logic                  flat_range;

   modport source (output valid, level, flat_range, input ready);
   modport sink   (input valid, level, flat_range, output ready);
endinterface

// File: sv/mmrb_ctrl.sv
// mmrb_ctrl: controller state machine, sequences measure, prepare, divide, output.
// Depends on mmrb_pkg.
module mmrb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mmrb_pkg::status_type status,
   output mmrb_pkg::cmd_type    cmd
);
   import mmrb_pkg::*;

   state_type            state_ff, state_in;
   logic [StepWidth-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.is_rescale) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == StepWidth'(QuotBits - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.measure = req_valid && !status.is_rescale;
            cmd.capture = req_valid && status.is_rescale;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: sv/mmrb_datapath.sv
// mmrb_datapath: range registers, restoring divider and output register.
// Depends on mmrb_pkg; driven by mmrb_ctrl commands.
module mmrb_datapath #(
   parameter int unsigned SAMPLE_WIDTH = mmrb_pkg::SampleWidthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mmrb_pkg::cmd_type                   cmd,
   output mmrb_pkg::status_type                status,
   input  logic                                req_opcode,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mmrb_pkg::LevelWidth-1:0]     rsp_level,
   output logic                                rsp_flat_range
);
   import mmrb_pkg::*;

   localparam int unsigned DW = SAMPLE_WIDTH + ScaleBits;

   logic signed [SAMPLE_WIDTH-1:0] lowest_ff, lowest_in;
   logic signed [SAMPLE_WIDTH-1:0] highest_ff, highest_in;
   logic                           range_open_ff, range_open_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;

   logic [DW-1:0]         rem_ff, rem_in;
   logic [DW-1:0]         sh_ff, sh_in;
   logic [QuotBits-1:0]   quot_ff, quot_in;
   logic                  flat_ff, below_ff, above_ff;

   logic                  valid_ff, valid_in;
   logic [LevelWidth-1:0] level_ff;
   logic                  flat_out_ff;

   logic signed [SAMPLE_WIDTH:0] diff_t;
   logic signed [SAMPLE_WIDTH:0] diff_d;
   logic [DW-1:0]                dividend;
   logic                         fits;

   // range tracking
   always_comb begin
      lowest_in     = lowest_ff;
      highest_in    = highest_ff;
      range_open_in = range_open_ff;
      if (cmd.measure) begin
         if (!range_open_ff) begin
            lowest_in  = req_sample;
            highest_in = req_sample;
         end else begin
            if (req_sample < lowest_ff)  lowest_in  = req_sample;
            if (req_sample > highest_ff) highest_in = req_sample;
         end
         range_open_in = !req_last;
      end
   end

   // offset from minimum, range width, and dividend 2*255*t + d
   always_comb begin
      diff_t   = {x_ff[SAMPLE_WIDTH-1], x_ff} - {lowest_ff[SAMPLE_WIDTH-1], lowest_ff};
      diff_d   = {highest_ff[SAMPLE_WIDTH-1], highest_ff}
               - {lowest_ff[SAMPLE_WIDTH-1], lowest_ff};
      dividend = DW'(diff_t[SAMPLE_WIDTH-1:0]) * DW'(2 * LevelMax)
               + DW'(diff_d[SAMPLE_WIDTH-1:0]);
   end

   // restoring divide, one quotient bit per step
   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      quot_in = quot_ff;
      fits    = (rem_ff >= sh_ff);
      if (cmd.prep) begin
         rem_in  = dividend;
         sh_in   = DW'(diff_d[SAMPLE_WIDTH-1:0]) << QuotBits;  // 2d aligned to top bit
         quot_in = '0;
      end else if (cmd.div_step) begin
         if (fits) begin
            rem_in = rem_ff - sh_ff;
         end
         quot_in = {quot_ff[QuotBits-2:0], fits};
         sh_in   = sh_ff >> 1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff     <= '0;
         highest_ff    <= '0;
         range_open_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         lowest_ff     <= lowest_in;
         highest_ff    <= highest_in;
         range_open_ff <= range_open_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      quot_ff <= quot_in;
      if (cmd.capture) begin
         x_ff <= req_sample;
      end
      if (cmd.prep) begin
         flat_ff  <= (diff_d == '0);
         below_ff <= diff_t[SAMPLE_WIDTH];
         above_ff <= (diff_t >= diff_d);
      end
      if (cmd.load_out) begin
         flat_out_ff <= flat_ff;
         if (flat_ff || below_ff) begin
            level_ff <= '0;
         end else if (above_ff) begin
            level_ff <= LevelWidth'(LevelMax);
         end else begin
            level_ff <= LevelWidth'(quot_ff);
         end
      end
   end

   assign status.is_rescale = (req_opcode == OpRescale);
   assign status.out_free   = !valid_ff || rsp_ready;

   assign rsp_valid      = valid_ff;
   assign rsp_level      = level_ff;
   assign rsp_flat_range = flat_out_ff;

endmodule

// File: sv/min_max_rescale_to_byte_top.sv
// min_max_rescale_to_byte_top: two-pass min/max normalizer to an 8-bit level.
// Depends on mmrb_pkg, mmrb_channels, mmrb_ctrl and mmrb_datapath.
//
// Usage:
//  - req_chan carries opcode, sample and last. Opcode measure folds the sample
//    into the running [min, max] range; the first measure after reset or after
//    a measure with last set starts a fresh range. Measure gives no response.
//  - Opcode rescale gives one rsp_chan transfer: level =
//    round((x - min) * 255 / (max - min)), half up, clamped to 0..255.
//    A flat range (max == min) returns level 0 with flat_range set.
//  - A new measure transfer is taken every cycle while no rescale is in progress.
//  - Rescale: the request transfer is followed by prepare, eight steps of the
//    restoring divider and the output load, then rsp valid; the divider sets the
//    pace. No new request is taken until the controller is back in idle.
//  - A result sits in the output register until rsp_chan is ready; measure
//    transfers are still taken meanwhile. A following rescale finishes its
//    divide and holds in its final state until the output register frees.
//  - Synchronous reset clears the range to 0..0 (flat) and drops rsp valid.
module min_max_rescale_to_byte_top #(
   parameter int unsigned SAMPLE_WIDTH = mmrb_pkg::SampleWidthDefault
) (
   input  logic       clock,
   input  logic       reset,
   mmrb_req_if.sink   req_chan,
   mmrb_rsp_if.source rsp_chan
);
   import mmrb_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ready;

   // controller: owns req ready and sequencing of the divide
   mmrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: range registers, divider, output register
   mmrb_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_chan.opcode),
      .req_sample     (req_chan.sample),
      .req_last       (req_chan.last),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_level      (rsp_chan.level),
      .rsp_flat_range (rsp_chan.flat_range)
   );

   assign req_chan.ready = ready;

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for min_max_rescale_to_byte_top.
// Depends on mmrb_pkg, mmrb_channels and the block's RTL; compile after them.
// Predicts every response from its own range tracker and checks level and flat flag.
module tb;
   import mmrb_pkg::*;

   localparam int unsigned SampleWidth = SampleWidthDefault;
   // no transfer on either channel for this many cycles means the block hung
   localparam int StallLimit = 3000;
   // length of the long response hold-off, in cycles
   localparam int HoldCycles = 150;
   // cycles to let the pipe settle at the end
   localparam int DrainCycles = 30;

   typedef struct {
      logic [LevelWidth-1:0] level;
      logic                  flat_range;
   } level_result_type;

   logic clock = 1'b0;
   logic reset;

   mmrb_req_if #(.SAMPLE_WIDTH(SampleWidth)) req_chan ();
   mmrb_rsp_if rsp_chan ();

   min_max_rescale_to_byte_top #(.SAMPLE_WIDTH(SampleWidth)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Range tracker: own copy of the block's state, updated on every request
   // transfer. Rescale transfers push the level they must produce.
   // ---------------------------------------------------------------------
   logic signed [SampleWidth-1:0] range_low  = '0;
   logic signed [SampleWidth-1:0] range_high = '0;
   logic                          range_open = 1'b0;
   level_result_type              expected_levels[$];

   int error_count     = 0;
   int measure_count   = 0;
   int rescale_count   = 0;
   int flat_count      = 0;
   int saturated_count = 0;
   int checked_count   = 0;

   // round half up of (x - low) * 255 / (high - low), clamped to 0..255
   function automatic logic [LevelWidth-1:0] scaled_level(
      input logic signed [SampleWidth-1:0] x);
      longint span, num, quot, top;
      top  = LevelMax;   // keep the arithmetic signed
      span = longint'(range_high) - longint'(range_low);
      num  = 2 * (longint'(x) - longint'(range_low)) * top + span;
      if (span <= 0 || num < 0) return '0;
      quot = num / (2 * span);
      if (quot > top) quot = top;
      return quot[LevelWidth-1:0];
   endfunction

   task automatic track_request(input logic op, input logic signed [SampleWidth-1:0] x,
                                input logic last_flag);
      level_result_type res;
      if (op == OpMeasure) begin
         measure_count++;
         if (!range_open) begin
            // first measure after reset or after a closing transfer
            range_low  = x;
            range_high = x;
            range_open = 1'b1;
         end else begin
            if (x < range_low)  range_low  = x;
            if (x > range_high) range_high = x;
         end
         if (last_flag) range_open = 1'b0;
      end else begin
         rescale_count++;
         if (range_high == range_low) begin
            res.level      = '0;
            res.flat_range = 1'b1;
            flat_count++;
         end else begin
            res.level      = scaled_level(x);
            res.flat_range = 1'b0;
            if (x < range_low || x > range_high) saturated_count++;
         end
         expected_levels.push_back(res);
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // request monitor: feed the tracker with every accepted request
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         track_request(req_chan.opcode, req_chan.sample, req_chan.last);
   end

   // response checker: compare each transfer with the oldest prediction
   always @(posedge clock) begin
      level_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         checked_count++;
         if (expected_levels.size() == 0) begin
            report_mismatch($sformatf("response level=%0d flat=%0b with nothing pending",
                                      rsp_chan.level, rsp_chan.flat_range));
         end else begin
            want = expected_levels.pop_front();
            if (rsp_chan.level !== want.level)
               report_mismatch($sformatf("level got %0d want %0d",
                                         rsp_chan.level, want.level));
            if (rsp_chan.flat_range !== want.flat_range)
               report_mismatch($sformatf("flat_range got %0b want %0b",
                                         rsp_chan.flat_range, want.flat_range));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random idling, plus a long hold-off on request.
   // The test bumps hold_req_id; this process owns the countdown.
   // ---------------------------------------------------------------------
   int send_idle_pct = 9;
   int recv_idle_pct = 54;
   int hold_req_id   = 0;
   int hold_seen_id  = 0;
   int hold_left     = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_req_id != hold_seen_id) begin
         hold_seen_id   <= hold_req_id;
         hold_left      <= HoldCycles;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: count cycles without any transfer on either channel
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("ERROR @%0t: no transfer for %0d cycles", $time, StallLimit);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one request and hold it until transferred. valid is left high on
   // return so back-to-back items need no extra cycle.
   task automatic send_item(input logic op, input int value, input logic last_flag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= op;
      req_chan.sample <= value[SampleWidth-1:0];
      req_chan.last   <= last_flag;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Sender pause: drop valid and wait until every predicted response is in.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   // random full-scale 16-bit sample, signed
   function automatic int any_sample();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   // Directed corners: flat cases, full-scale range, rounding, saturation,
   // rescale into an open range, last flag on a rescale.
   task automatic test_directed();
      send_item(OpRescale, 0, 1'b0);        // before any measure: reset range is flat
      send_item(OpRescale, 32767, 1'b1);    // last on rescale has no effect
      send_item(OpMeasure, 1234, 1'b1);     // one sample opens and closes the range
      send_item(OpRescale, 1234, 1'b0);     // single-sample range is flat
      send_item(OpMeasure, -32768, 1'b0);   // full-scale range
      send_item(OpMeasure, 32767, 1'b1);
      send_item(OpRescale, -32768, 1'b0);
      send_item(OpRescale, 32767, 1'b0);
      send_item(OpRescale, 0, 1'b0);
      send_item(OpRescale, -1, 1'b0);
      send_item(OpMeasure, 0, 1'b0);        // range 0..2: midpoint rounds up
      send_item(OpMeasure, 2, 1'b1);
      send_item(OpRescale, 1, 1'b0);
      send_item(OpRescale, -5, 1'b0);       // below the range: clamps low
      send_item(OpRescale, 100, 1'b0);      // above the range: clamps high
      send_item(OpMeasure, 10, 1'b0);       // range left open
      send_item(OpRescale, 10, 1'b0);       // open and still flat
      send_item(OpMeasure, -10, 1'b0);
      send_item(OpRescale, 0, 1'b0);        // uses the open range -10..10
      send_item(OpMeasure, 30, 1'b1);
      send_item(OpRescale, 30, 1'b0);
      send_item(OpRescale, 11, 1'b1);
      send_item(OpMeasure, -21846, 1'b0);   // alternating bit patterns
      send_item(OpMeasure, 21845, 1'b1);
      send_item(OpRescale, 0, 1'b0);
   endtask

   // Mostly well-formed passes (measure a range, close it, replay samples),
   // with some unstructured noise mixed in.
   task automatic test_random_passes(input int item_budget);
      int sent, n_meas, n_resc, width, base, hi, x, lo_seen, hi_seen, pick;
      sent = 0;
      while (sent < item_budget) begin
         if ($urandom_range(99) < 80) begin
            n_meas = $urandom_range(1, 12);
            pick   = $urandom_range(99);
            if (pick < 10)      width = 0;
            else if (pick < 35) width = $urandom_range(1, 4);
            else if (pick < 70) width = $urandom_range(5, 300);
            else                width = $urandom_range(301, 65535);
            base = any_sample();
            hi   = (base + width > 32767) ? 32767 : base + width;
            lo_seen = hi;
            hi_seen = base;
            for (int i = 0; i < n_meas; i++) begin
               x = base + int'($urandom_range(hi - base));
               if (x < lo_seen) lo_seen = x;
               if (x > hi_seen) hi_seen = x;
               send_item(OpMeasure, x, i == n_meas - 1);
            end
            n_resc = $urandom_range(1, 10);
            for (int i = 0; i < n_resc; i++) begin
               pick = $urandom_range(99);
               if (pick < 70)      x = lo_seen + int'($urandom_range(hi_seen - lo_seen));
               else if (pick < 80) x = ($urandom_range(1)) ? lo_seen : hi_seen;
               else                x = any_sample();
               send_item(OpRescale, x, $urandom_range(9) == 0);
            end
            sent += n_meas + n_resc;
         end else begin
            n_meas = $urandom_range(1, 6);
            for (int i = 0; i < n_meas; i++)
               send_item(1'($urandom_range(1)), any_sample(), $urandom_range(4) == 0);
            sent += n_meas;
         end
      end
   endtask

   // Long response hold-off while requests keep coming, so the output
   // register and the divider fill and the request side stalls.
   task automatic test_long_hold();
      int saved_idle;
      saved_idle    = send_idle_pct;
      send_idle_pct = 0;
      hold_req_id++;
      send_item(OpMeasure, -1000, 1'b0);
      send_item(OpMeasure, 3000, 1'b1);
      for (int i = 0; i < 20; i++)
         send_item(i % 4 == 3 ? OpMeasure : OpRescale, any_sample(), 1'b0);
      send_idle_pct = saved_idle;
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.opcode <= OpMeasure;
      req_chan.sample <= '0;
      req_chan.last   <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles rarely, receiver often
      send_idle_pct = 9;
      recv_idle_pct = 54;
      test_directed();
      wait_for_results();
      test_random_passes(460);
      test_long_hold();
      wait_for_results();

      // sender idles often, receiver rarely
      send_idle_pct = 54;
      recv_idle_pct = 9;
      test_random_passes(460);
      wait_for_results();

      // full rate both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_passes(460);
      wait_for_results();
      repeat (DrainCycles) @(posedge clock);

      $display("Run covered %0d measure and %0d rescale transfers (%0d flat, %0d clamped)",
               measure_count, rescale_count, flat_count, saturated_count);
      $display("%0d responses checked, %0d mismatches", checked_count, error_count);
      if (error_count == 0 && expected_levels.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
